// File: design/gaussian_3x3_stream_filter_unit_assert.svh
// Assertion macros shared by the Gaussian 3x3 stream filter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef GAUSSIAN_3X3_STREAM_FILTER_UNIT_ASSERT_SVH
`define GAUSSIAN_3X3_STREAM_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define G3_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gauss3 assertion failed");

// The expression must hold at every clock edge out of reset.
`define G3_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("gauss3 assertion failed");

`endif

// File: design/gauss3_pkg.sv
// Shared constants and register codes of the Gaussian 3x3 stream filter.
// Used by the top level; has no dependencies.
package gauss3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int KERNEL_SIZE    = 3;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 12;
    localparam int WEIGHT_BITS    = 8;
    localparam int SHIFT_BITS     = 4;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [WIDTH_BITS-1:0]  RST_IMAGE_WIDTH   = 11'd3;
    localparam logic [HEIGHT_BITS-1:0] RST_IMAGE_HEIGHT  = 12'd3;
    localparam logic [WEIGHT_BITS-1:0] RST_CORNER_WEIGHT = 8'd1;
    localparam logic [WEIGHT_BITS-1:0] RST_EDGE_WEIGHT   = 8'd2;
    localparam logic [WEIGHT_BITS-1:0] RST_CENTER_WEIGHT = 8'd4;
    localparam logic [SHIFT_BITS-1:0]  RST_NORM_SHIFT    = 4'd4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_CORNER_WEIGHT = 3'd2,
        REG_EDGE_WEIGHT   = 3'd3,
        REG_CENTER_WEIGHT = 3'd4,
        REG_NORM_SHIFT    = 3'd5
    } cfg_reg_t;

endpackage

// File: design/gauss3_line_mem.sv
// Two-row line store of the Gaussian 3x3 stream filter: one entry per column
// holds the pixels one and two rows above. Simple dual port, registered read.
module gauss3_line_mem #(
    parameter int DEPTH = 1024,
    parameter int DATA_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_BITS-1:0]     rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_BITS-1:0]     wr_data
);

    logic [DATA_BITS-1:0] mem_reg [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/gaussian_3x3_stream_filter_unit.sv
// Gaussian 3x3 stream filter: takes one pixel per clock in raster order and
// returns one filtered pixel per interior position, (width-2) x (height-2)
// results per image, with tlast on the last one. Sustained rate is one pixel
// per clock; the line store is read at the pixel's column when the word is
// taken and written back from the stage-1 register; a result runs through
// stages 1 to 3. Input stalls only when a result must enter a full output
// register. Write configuration only while the filter is idle.
`include "gaussian_3x3_stream_filter_unit_assert.svh"

module gaussian_3x3_stream_filter_unit #(
    parameter int MAX_WIDTH  = gauss3_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = gauss3_pkg::DEF_PIXEL_BITS,
    localparam int TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gauss3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gauss3_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // Pixel input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [TDATA_BITS-1:0]               s_tdata,  // [PIXEL_BITS-1:0] pixel_in
    // Filtered output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [TDATA_BITS-1:0]               m_tdata,  // [PIXEL_BITS-1:0] pixel_out
    output logic                                m_tlast   // frame_end
);

    localparam int ADDR_BITS = $clog2(MAX_WIDTH);
    localparam int COL_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int EXT_BITS  = (COL_BITS > gauss3_pkg::WIDTH_BITS) ?
                               COL_BITS : gauss3_pkg::WIDTH_BITS;
    localparam int HB        = gauss3_pkg::HEIGHT_BITS;
    localparam int GROUP_BITS = PIXEL_BITS + 2;
    localparam int PROD_BITS = GROUP_BITS + gauss3_pkg::WEIGHT_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;
    localparam logic [PIXEL_BITS-1:0] PIX_MAX = {PIXEL_BITS{1'b1}};

    // Configuration registers.
    logic [gauss3_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [HB-1:0]                      height_reg;
    logic [gauss3_pkg::WEIGHT_BITS-1:0] corner_w_reg;
    logic [gauss3_pkg::WEIGHT_BITS-1:0] edge_w_reg;
    logic [gauss3_pkg::WEIGHT_BITS-1:0] center_w_reg;
    logic [gauss3_pkg::SHIFT_BITS-1:0]  shift_reg;

    // Position counters.
    logic [ADDR_BITS-1:0] col_reg, col_next;
    logic [HB-1:0]        row_reg, row_next;

    logic [EXT_BITS-1:0] width_ext, w_eff, w_last;
    logic [HB-1:0]       h_eff, h_last;
    logic                col_last, row_last;

    logic cfg_acc, in_acc, adv;

    // Stage 1: line store read in flight.
    logic                  v1_reg, res1_reg, last1_reg;
    logic [PIXEL_BITS-1:0] pix1_reg;
    logic [ADDR_BITS-1:0]  col1_reg;

    // Stage 2: neighbor group sums.
    logic                  v2_reg, last2_reg;
    logic [GROUP_BITS-1:0] corners2_reg, edges2_reg;
    logic [PIXEL_BITS-1:0] center2_reg;

    // Stage 3: weighted products.
    logic                  v3_reg, last3_reg;
    logic [PROD_BITS-1:0]  corner_p3_reg, edge_p3_reg, center_p3_reg;

    // Output register.
    logic                  m_tvalid_reg, m_tlast_reg;
    logic [PIXEL_BITS-1:0] m_pix_reg;

    // Window: [0..2] oldest column top to bottom, [3..5] middle column.
    logic [PIXEL_BITS-1:0] win_reg [6];

    logic [2*PIXEL_BITS-1:0] rd_data;
    logic [PIXEL_BITS-1:0]   top, mid;
    logic                    mem_we;

    logic [SUM_BITS-1:0] sum, shifted;
    logic [PIXEL_BITS-1:0] sat_pix;

    // ---------------------------------------------------------------------
    // Geometry
    // ---------------------------------------------------------------------
    always_comb begin
        width_ext = EXT_BITS'(width_reg);
        if (width_ext < EXT_BITS'(gauss3_pkg::KERNEL_SIZE)) begin
            w_eff = EXT_BITS'(gauss3_pkg::KERNEL_SIZE);
        end else if (width_ext > EXT_BITS'(MAX_WIDTH)) begin
            w_eff = EXT_BITS'(MAX_WIDTH);
        end else begin
            w_eff = width_ext;
        end
        w_last = w_eff - EXT_BITS'(1);

        if (height_reg < HB'(gauss3_pkg::KERNEL_SIZE)) begin
            h_eff = HB'(gauss3_pkg::KERNEL_SIZE);
        end else begin
            h_eff = height_reg;
        end
        h_last = h_eff - HB'(1);

        col_last = (EXT_BITS'(col_reg) == w_last);
        row_last = (row_reg == h_last);
    end

    // ---------------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------------
    // The pipeline moves unless a result would land on an output word that
    // is still waiting; bubbles keep flowing past a stalled output.
    assign adv       = !(v3_reg && m_tvalid_reg && !m_tready);
    assign s_tready  = adv;
    assign in_acc    = s_tvalid && adv;
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc) begin
            if (col_last) begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + HB'(1);
            end else begin
                col_next = col_reg + ADDR_BITS'(1);
            end
        end
        if (cfg_acc && (cfg_index == gauss3_pkg::REG_IMAGE_WIDTH ||
                        cfg_index == gauss3_pkg::REG_IMAGE_HEIGHT)) begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= gauss3_pkg::RST_IMAGE_WIDTH;
            height_reg   <= gauss3_pkg::RST_IMAGE_HEIGHT;
            corner_w_reg <= gauss3_pkg::RST_CORNER_WEIGHT;
            edge_w_reg   <= gauss3_pkg::RST_EDGE_WEIGHT;
            center_w_reg <= gauss3_pkg::RST_CENTER_WEIGHT;
            shift_reg    <= gauss3_pkg::RST_NORM_SHIFT;
            col_reg      <= '0;
            row_reg      <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_acc) begin
                case (cfg_index)
                    gauss3_pkg::REG_IMAGE_WIDTH:
                        width_reg <= cfg_data[gauss3_pkg::WIDTH_BITS-1:0];
                    gauss3_pkg::REG_IMAGE_HEIGHT:
                        height_reg <= cfg_data[HB-1:0];
                    gauss3_pkg::REG_CORNER_WEIGHT:
                        corner_w_reg <= cfg_data[gauss3_pkg::WEIGHT_BITS-1:0];
                    gauss3_pkg::REG_EDGE_WEIGHT:
                        edge_w_reg <= cfg_data[gauss3_pkg::WEIGHT_BITS-1:0];
                    gauss3_pkg::REG_CENTER_WEIGHT:
                        center_w_reg <= cfg_data[gauss3_pkg::WEIGHT_BITS-1:0];
                    gauss3_pkg::REG_NORM_SHIFT:
                        shift_reg <= cfg_data[gauss3_pkg::SHIFT_BITS-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Line store: read at accept, write back the shifted column from stage 1.
    // Consecutive pixels hit different columns (width is at least three), so
    // a column is never read while its write back is still pending.
    // ---------------------------------------------------------------------
    assign top    = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
    assign mid    = rd_data[PIXEL_BITS-1:0];
    assign mem_we = adv && v1_reg;

    gauss3_line_mem #(
        .DEPTH     (MAX_WIDTH),
        .DATA_BITS (2 * PIXEL_BITS)
    ) u_line_mem (
        .aclk    (aclk),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (col1_reg),
        .wr_data ({mid, pix1_reg})
    );

    // ---------------------------------------------------------------------
    // Pipeline
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (adv) begin
            v1_reg <= in_acc;
            v2_reg <= v1_reg && res1_reg;
            v3_reg <= v2_reg;
            if (v1_reg) begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= pix1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pix1_reg  <= s_tdata[PIXEL_BITS-1:0];
            col1_reg  <= col_reg;
            res1_reg  <= (row_reg >= HB'(2)) && (col_reg >= ADDR_BITS'(2));
            last1_reg <= row_last && col_last;

            corners2_reg <= GROUP_BITS'(win_reg[0]) + GROUP_BITS'(win_reg[2])
                          + GROUP_BITS'(top) + GROUP_BITS'(pix1_reg);
            edges2_reg   <= GROUP_BITS'(win_reg[1]) + GROUP_BITS'(win_reg[3])
                          + GROUP_BITS'(win_reg[5]) + GROUP_BITS'(mid);
            center2_reg  <= win_reg[4];
            last2_reg    <= last1_reg;

            corner_p3_reg <= PROD_BITS'(corners2_reg) * PROD_BITS'(corner_w_reg);
            edge_p3_reg   <= PROD_BITS'(edges2_reg) * PROD_BITS'(edge_w_reg);
            center_p3_reg <= PROD_BITS'(center2_reg) * PROD_BITS'(center_w_reg);
            last3_reg     <= last2_reg;
        end
    end

    always_comb begin
        sum     = SUM_BITS'(corner_p3_reg) + SUM_BITS'(edge_p3_reg)
                + SUM_BITS'(center_p3_reg);
        shifted = sum >> shift_reg;
        sat_pix = (shifted > SUM_BITS'(PIX_MAX)) ? PIX_MAX : shifted[PIXEL_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (v3_reg && adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (v3_reg && adv) begin
            m_pix_reg   <= sat_pix;
            m_tlast_reg <= last3_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_BITS'(m_pix_reg);
    assign m_tlast  = m_tlast_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `G3_ASSERT_IMPLIES(a_no_column_clash, aclk, aresetn,
        in_acc && mem_we, col_reg != col1_reg)
    `G3_ASSERT_ALWAYS(a_col_in_row, aclk, aresetn, EXT_BITS'(col_reg) <= w_last)
    `G3_ASSERT_ALWAYS(a_row_in_image, aclk, aresetn, row_reg <= h_last)
    `G3_ASSERT_IMPLIES(a_result_not_dropped, aclk, aresetn,
        v3_reg && m_tvalid_reg && !m_tready, !s_tready)

endmodule
